>>> design/mipmap_box_pyramid_core_macros.svh
// Assertion macros shared by the mip pyramid design files.
// Depends on nothing; included by files that carry assertions.
`ifndef MIPMAP_BOX_PYRAMID_CORE_MACROS_SVH
`define MIPMAP_BOX_PYRAMID_CORE_MACROS_SVH
`define MBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MBP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/mbp_pkg.sv
// Shared constants and types of the mip pyramid generator.
// Depends on nothing.
`timescale 1ns / 1ps
package mbp_pkg;
   localparam int MaxSizeLog2 = 10;
   localparam int LevelWidth = 4;
   localparam int PosWidth = 9;
   localparam int ChanWidth = 8;
   localparam int PixWidth = 4 * ChanWidth;
   localparam int PairChanWidth = ChanWidth + 1;
   localparam int PairWidth = 4 * PairChanWidth;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 4;
   localparam logic [CsrIndexWidth-1:0] CsrWidthLog2 = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrHeightLog2 = 1'b1;

   typedef struct packed {
      logic [PixWidth-1:0] pixel;
   } mbp_job_type;

   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic [PosWidth-1:0] pos_x;
      logic [PosWidth-1:0] pos_y;
      logic [ChanWidth-1:0] avg_red;
      logic [ChanWidth-1:0] avg_green;
      logic [ChanWidth-1:0] avg_blue;
      logic [ChanWidth-1:0] avg_alpha;
      logic run_last;
      logic pyramid_done;
   } mbp_result_type;
endpackage

>>> design/mbp_req_if.sv
// Handshake interfaces for the base pixel and result channels.
// Depends on mbp_pkg.
`timescale 1ns / 1ps
interface mbp_req_if import mbp_pkg::*; ();
   logic valid;
   logic ready;
   logic [ChanWidth-1:0] red;
   logic [ChanWidth-1:0] green;
   logic [ChanWidth-1:0] blue;
   logic [ChanWidth-1:0] alpha;
   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface mbp_rsp_if import mbp_pkg::*; ();
   logic valid;
   logic ready;
   mbp_result_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> design/mbp_front.sv
// Front end: accepts base pixels into a short queue for the level engine.
// Depends on mbp_pkg.
`timescale 1ns / 1ps
module mbp_front import mbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  mbp_job_type in_job,
   output logic out_valid,
   input  logic out_ready,
   output mbp_job_type out_job
);
   mbp_job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= in_job;
   end
endmodule

>>> design/mbp_back.sv
// Level engine: walks the levels for one pixel, taking a new pixel only when idle.
// Depends on mbp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "mipmap_box_pyramid_core_macros.svh"
module mbp_back import mbp_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = MaxSizeLog2
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   input  logic job_valid,
   output logic job_ready,
   input  mbp_job_type job,
   output logic res_valid,
   input  logic res_ready,
   output mbp_result_type res
);
   localparam int LW = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int KW = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
   localparam int CW = MAX_SIZE_LOG2;
   localparam int Depth = (1 << MAX_SIZE_LOG2) - 1;
   localparam int AW = MAX_SIZE_LOG2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LEVEL = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CsrDataWidth-1:0] wl_reg_ff, hl_reg_ff;
   logic [LW-1:0] wl, hl, levels;
   logic [CW-1:0] col_ff [MAX_SIZE_LOG2];
   logic [CW-1:0] row_ff [MAX_SIZE_LOG2];
   logic [PixWidth-1:0] held_ff [MAX_SIZE_LOG2];
   logic [PairWidth-1:0] pair_mem [Depth];
   logic [PairWidth-1:0] mem_rd_ff;
   logic [PixWidth-1:0] pix_ff;
   logic [KW-1:0] k_ff;
   logic [PairWidth-1:0] pair_ff, pair;
   logic [CW-1:0] x_ff, y_ff;
   logic [CW:0] wk, hk;
   logic [CW-1:0] x, y;
   logic [AW-1:0] idx;
   logic obuf_v_ff;
   mbp_result_type obuf_ff, r;
   logic [PixWidth-1:0] next_pix;
   logic last_lvl;

   always_comb begin
      wl = (wl_reg_ff > CsrDataWidth'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2) : LW'(wl_reg_ff);
      hl = (hl_reg_ff > CsrDataWidth'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2) : LW'(hl_reg_ff);
      levels = (wl < hl) ? wl : hl;
   end

   assign x = col_ff[k_ff];
   assign y = row_ff[k_ff];
   assign wk = (CW+1)'(1) << (wl - LW'(k_ff));
   assign hk = (CW+1)'(1) << (hl - LW'(k_ff));
   assign idx = AW'(((AW+1)'(1) << AW) - ((AW+1)'(1) << (AW - KW'(0) - k_ff)))
                + AW'(x >> 1);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         pair[c*PairChanWidth +: PairChanWidth] =
            {1'b0, held_ff[k_ff][c*ChanWidth +: ChanWidth]} +
            {1'b0, pix_ff[c*ChanWidth +: ChanWidth]};
      end
   end

   always_comb begin
      logic [PairChanWidth:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         t = {1'b0, mem_rd_ff[c*PairChanWidth +: PairChanWidth]} +
             {1'b0, pair_ff[c*PairChanWidth +: PairChanWidth]};
         next_pix[c*ChanWidth +: ChanWidth] = t[PairChanWidth:2];
      end
      last_lvl = (LW'(k_ff) + LW'(1)) == levels;
      r.level = LevelWidth'(k_ff) + LevelWidth'(1);
      r.pos_x = PosWidth'(x_ff >> 1);
      r.pos_y = PosWidth'(y_ff >> 1);
      r.avg_red = next_pix[0 +: ChanWidth];
      r.avg_green = next_pix[ChanWidth +: ChanWidth];
      r.avg_blue = next_pix[2*ChanWidth +: ChanWidth];
      r.avg_alpha = next_pix[3*ChanWidth +: ChanWidth];
      r.run_last = last_lvl || !(col_ff[k_ff + KW'(1)][0] && row_ff[k_ff + KW'(1)][0]
                   && col_ff[k_ff + KW'(1)][0]);
      r.pyramid_done = last_lvl && (CW+1)'(x_ff >> 1) == ((wk >> 1) - (CW+1)'(1))
                       && (CW+1)'(y_ff >> 1) == ((hk >> 1) - (CW+1)'(1));
   end

   logic emit;
   assign emit = state_ff == ST_MERGE && !obuf_v_ff;
   assign job_ready = state_ff == ST_IDLE;
   assign res_valid = obuf_v_ff;
   assign res = obuf_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = (levels == '0) ? ST_IDLE : ST_LEVEL;
         ST_LEVEL: begin
            if (!x[0] || !y[0]) state_in = ST_IDLE;
            else state_in = ST_MERGE;
         end
         ST_MERGE: if (emit) state_in = last_lvl ? ST_IDLE : ST_LEVEL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wl_reg_ff <= CsrDataWidth'(8);
         hl_reg_ff <= CsrDataWidth'(8);
         obuf_v_ff <= 1'b0;
         k_ff <= '0;
         for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (res_valid && res_ready) obuf_v_ff <= 1'b0;
         if (emit) begin
            obuf_v_ff <= 1'b1;
            k_ff <= k_ff + KW'(1);
            pix_ff <= next_pix;
         end
         if (state_ff == ST_IDLE && job_valid) begin
            pix_ff <= job.pixel;
            k_ff <= '0;
         end
         if (csr_write) begin
            if (csr_index == CsrWidthLog2) wl_reg_ff <= csr_data;
            if (csr_index == CsrHeightLog2) hl_reg_ff <= csr_data;
            for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
               col_ff[i] <= '0;
               row_ff[i] <= '0;
            end
         end else if (state_ff == ST_LEVEL) begin
            if (({1'b0, x} + (CW+1)'(1)) >= wk) begin
               col_ff[k_ff] <= '0;
               row_ff[k_ff] <= (({1'b0, y} + (CW+1)'(1)) >= hk) ? '0 : y + CW'(1);
            end else begin
               col_ff[k_ff] <= x + CW'(1);
            end
         end
         if (state_ff == ST_LEVEL) begin
            x_ff <= x;
            y_ff <= y;
            pair_ff <= pair;
         end
      end
      if (state_ff == ST_LEVEL) begin
         if (!x[0]) held_ff[k_ff] <= pix_ff;
         else if (!y[0]) pair_mem[idx] <= pair;
         mem_rd_ff <= pair_mem[idx];
      end
      if (emit) obuf_ff <= r;
   end

   `MBP_ASSERT_IMP(a_ready_idle, clock, reset, job_ready, state_ff == ST_IDLE, "ready outside idle")
   `MBP_ASSERT_NXT(a_emit_valid, clock, reset, emit, res_valid, "emitted result not shown")
   `MBP_ASSERT_IMP(a_level_range, clock, reset, res_valid, res.level != '0, "zero level")
endmodule

>>> design/mipmap_box_pyramid_core.sv
// Top level of the streaming 2x2 box-filter mip pyramid generator.
// Depends on mbp_pkg, the channel interfaces, mbp_front and mbp_back.
//
// Base RGBA pixels enter on the req channel in raster order, one word per
// handshake. Each completed 2x2 block at any level yields one rsp word with
// its level, position and averaged channels, in rising level order; run_last
// marks the last word caused by a pixel and pyramid_done the final pixel.
// The csr port sets log2 width (index 0) and log2 height (index 1); a write
// restarts the pyramid. A two-entry queue decouples pixel acceptance from
// the level engine. The engine takes a pixel in its idle state, visits each
// level in a level state and, when a 2x2 block completes, moves to a merge
// state that writes the result into an output register; with no levels it
// stays idle. While the receiver stalls, the engine holds in the merge
// state and the queue fills, then req_ready falls.
// Synchronous reset clears the counters and restores sizes of 256 by 256;
// the line store needs no clearing as every entry is written before use.
`timescale 1ns / 1ps
module mipmap_box_pyramid_core import mbp_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = MaxSizeLog2
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   mbp_req_if.sink req,
   mbp_rsp_if.source rsp
);
   mbp_job_type in_job, q_job;
   logic q_valid, q_ready;

   assign in_job.pixel = {req.alpha, req.blue, req.green, req.red};

   mbp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_job(in_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   mbp_back #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_back (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .res_valid(rsp.valid), .res_ready(rsp.ready), .res(rsp.data)
   );
endmodule
